[hw/rtl/degenerate_cell_collapse_macros.svh]
// Assertion macros for the degenerate cell collapse block.
`ifndef DEGENERATE_CELL_COLLAPSE_MACROS_SVH
`define DEGENERATE_CELL_COLLAPSE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DCC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dcc assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define DCC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dcc assertion failed");

`endif

[hw/rtl/dcc_pkg.sv]
// Shared types and codes for the degenerate cell collapse block.
package dcc_pkg;

    localparam int unsigned ID_W  = 31;
    localparam int unsigned OUT_W = 32;

    // Input cell kinds
    localparam logic [2:0] CELL_TRI   = 3'd0;
    localparam logic [2:0] CELL_QUAD  = 3'd1;
    localparam logic [2:0] CELL_TET   = 3'd2;
    localparam logic [2:0] CELL_PRISM = 3'd3;
    localparam logic [2:0] CELL_HEX   = 3'd4;

    // Result kinds
    localparam logic [3:0] K_NODE    = 4'd0;
    localparam logic [3:0] K_BAR     = 4'd1;
    localparam logic [3:0] K_TRI     = 4'd2;
    localparam logic [3:0] K_QUAD    = 4'd3;
    localparam logic [3:0] K_TET     = 4'd4;
    localparam logic [3:0] K_PYRA    = 4'd5;
    localparam logic [3:0] K_PRISM   = 4'd6;
    localparam logic [3:0] K_HEX     = 4'd7;
    localparam logic [3:0] K_INVALID = 4'd8;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_UNSUP = 1'b1;

    localparam logic signed [OUT_W-1:0] UNUSED_ID = -32'sd1;

    typedef struct packed {
        logic [2:0]      cell_kind;
        logic [ID_W-1:0] id0;
        logic [ID_W-1:0] id1;
        logic [ID_W-1:0] id2;
        logic [ID_W-1:0] id3;
        logic [ID_W-1:0] id4;
        logic [ID_W-1:0] id5;
        logic [ID_W-1:0] id6;
        logic [ID_W-1:0] id7;
    } cell_t;

    typedef struct packed {
        logic [3:0]               new_kind;
        logic                     status;
        logic signed [OUT_W-1:0]  out0;
        logic signed [OUT_W-1:0]  out1;
        logic signed [OUT_W-1:0]  out2;
        logic signed [OUT_W-1:0]  out3;
        logic signed [OUT_W-1:0]  out4;
        logic signed [OUT_W-1:0]  out5;
        logic signed [OUT_W-1:0]  out6;
        logic signed [OUT_W-1:0]  out7;
    } result_t;

endpackage

[hw/rtl/dcc_if.sv]
// Request channel interfaces: cell in, collapsed result out.
interface dcc_cell_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cell_kind;
    logic [30:0] id0;
    logic [30:0] id1;
    logic [30:0] id2;
    logic [30:0] id3;
    logic [30:0] id4;
    logic [30:0] id5;
    logic [30:0] id6;
    logic [30:0] id7;

    modport source (output valid, cell_kind, id0, id1, id2, id3, id4, id5, id6, id7,
                    input ready);
    modport sink (input valid, cell_kind, id0, id1, id2, id3, id4, id5, id6, id7,
                  output ready);
endinterface

interface dcc_result_if;
    logic               valid;
    logic               ready;
    logic [3:0]         new_kind;
    logic               status;
    logic signed [31:0] out0;
    logic signed [31:0] out1;
    logic signed [31:0] out2;
    logic signed [31:0] out3;
    logic signed [31:0] out4;
    logic signed [31:0] out5;
    logic signed [31:0] out6;
    logic signed [31:0] out7;

    modport source (output valid, new_kind, status, out0, out1, out2, out3, out4, out5,
                    out6, out7, input ready);
    modport sink (input valid, new_kind, status, out0, out1, out2, out3, out4, out5,
                  out6, out7, output ready);
endinterface

[hw/rtl/dcc_collapse.sv]
// Combinational collapse of one cell: distinct-id count and rewrite rules.
module dcc_collapse (
    input  dcc_pkg::cell_t   cell_in,
    output dcc_pkg::result_t res_out
);

    typedef struct packed {
        logic [3:0]                       kind;
        logic signed [dcc_pkg::OUT_W-1:0] v0;
        logic signed [dcc_pkg::OUT_W-1:0] v1;
        logic signed [dcc_pkg::OUT_W-1:0] v2;
    } tri_res_t;

    function automatic logic signed [dcc_pkg::OUT_W-1:0] wid(
        input logic [dcc_pkg::ID_W-1:0] x);
        return {1'b0, x};
    endfunction

    // Triangle rule on three ids
    function automatic tri_res_t tri_fn(input logic [dcc_pkg::ID_W-1:0] x0,
                                        input logic [dcc_pkg::ID_W-1:0] x1,
                                        input logic [dcc_pkg::ID_W-1:0] x2);
        tri_res_t r;
        r.v0 = wid(x0);
        if (x0 != x1 && x1 != x2 && x0 != x2) begin
            r.kind = dcc_pkg::K_TRI;
            r.v1   = wid(x1);
            r.v2   = wid(x2);
        end else if (x0 == x1 && x1 == x2) begin
            r.kind = dcc_pkg::K_NODE;
            r.v1   = dcc_pkg::UNUSED_ID;
            r.v2   = dcc_pkg::UNUSED_ID;
        end else begin
            r.kind = dcc_pkg::K_BAR;
            r.v1   = (x0 == x1) ? wid(x2) : wid(x1);
            r.v2   = dcc_pkg::UNUSED_ID;
        end
        return r;
    endfunction

    logic [7:0][dcc_pkg::ID_W-1:0]           t;
    logic [7:0][7:0]                         eq;
    logic [7:0]                              fresh;
    logic [3:0]                              n;
    logic [3:0]                              u;
    logic signed [7:0][dcc_pkg::OUT_W-1:0]   v;
    logic signed [7:0][dcc_pkg::OUT_W-1:0]   orig;
    logic [3:0]                              nk;
    logic                                    st;
    tri_res_t                                tr;
    logic [dcc_pkg::ID_W-1:0]                q0, q1, q2;
    logic                                    qbad;
    logic                                    seen;

    assign t[0] = cell_in.id0;
    assign t[1] = cell_in.id1;
    assign t[2] = cell_in.id2;
    assign t[3] = cell_in.id3;
    assign t[4] = cell_in.id4;
    assign t[5] = cell_in.id5;
    assign t[6] = cell_in.id6;
    assign t[7] = cell_in.id7;

    always_comb
    begin
        case (cell_in.cell_kind)
            dcc_pkg::CELL_TRI:   n = 4'd3;
            dcc_pkg::CELL_QUAD:  n = 4'd4;
            dcc_pkg::CELL_TET:   n = 4'd4;
            dcc_pkg::CELL_PRISM: n = 4'd6;
            dcc_pkg::CELL_HEX:   n = 4'd8;
            default:             n = 4'd0;
        endcase

        for (int i = 0; i < 8; i++)
        begin
            for (int j = 0; j < 8; j++)
            begin
                eq[i][j] = (t[i] == t[j]);
            end
        end

        // An id counts once, at its first slot within the cell
        for (int i = 0; i < 8; i++)
        begin
            seen = 1'b0;
            for (int j = 0; j < i; j++)
            begin
                seen = seen | eq[j][i];
            end
            fresh[i] = (4'(i) < n) && !seen;
        end

        u = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            u = u + 4'(fresh[i]);
        end

        for (int i = 0; i < 8; i++)
        begin
            orig[i] = (4'(i) < n) ? wid(t[i]) : dcc_pkg::UNUSED_ID;
            v[i]    = dcc_pkg::UNUSED_ID;
        end

        nk   = dcc_pkg::K_INVALID;
        st   = dcc_pkg::STATUS_OK;
        tr   = tri_fn(t[0], t[1], t[2]);
        q0   = t[0];
        q1   = t[1];
        q2   = t[2];
        qbad = 1'b0;

        case (cell_in.cell_kind)
            dcc_pkg::CELL_TRI:
            begin
                nk   = tr.kind;
                v[0] = tr.v0;
                v[1] = tr.v1;
                v[2] = tr.v2;
            end
            dcc_pkg::CELL_QUAD:
            begin
                if (u == 4'd4)
                begin
                    nk = dcc_pkg::K_QUAD;
                    v  = orig;
                end else if (u == 4'd1)
                begin
                    nk   = dcc_pkg::K_NODE;
                    v[0] = wid(t[0]);
                end else
                begin
                    if (eq[0][1])
                    begin
                        q1 = t[2];
                        q2 = t[3];
                    end else if (eq[1][2])
                    begin
                        q2 = t[3];
                    end else if (!(eq[2][3] || eq[0][3]))
                    begin
                        qbad = 1'b1;
                    end
                    tr = tri_fn(q0, q1, q2);
                    if (qbad)
                    begin
                        nk = dcc_pkg::K_INVALID;
                    end else if (u == 4'd3)
                    begin
                        nk   = dcc_pkg::K_TRI;
                        v[0] = wid(q0);
                        v[1] = wid(q1);
                        v[2] = wid(q2);
                    end else
                    begin
                        nk   = tr.kind;
                        v[0] = tr.v0;
                        v[1] = tr.v1;
                        v[2] = tr.v2;
                    end
                end
            end
            dcc_pkg::CELL_TET:
            begin
                if (u == 4'd4)
                begin
                    nk = dcc_pkg::K_TET;
                    v  = orig;
                end else if (u == 4'd1)
                begin
                    nk   = dcc_pkg::K_NODE;
                    v[0] = wid(t[0]);
                end else if (u == 4'd2)
                begin
                    nk = dcc_pkg::K_TET;
                    st = dcc_pkg::STATUS_UNSUP;
                    v  = orig;
                end else
                begin
                    nk   = dcc_pkg::K_TRI;
                    v[0] = wid(t[0]);
                    if (eq[0][1])
                    begin
                        v[1] = wid(t[2]);
                        v[2] = wid(t[3]);
                    end else if (eq[0][2] || eq[1][2])
                    begin
                        v[1] = wid(t[1]);
                        v[2] = wid(t[3]);
                    end else
                    begin
                        v[1] = wid(t[1]);
                        v[2] = wid(t[2]);
                    end
                end
            end
            dcc_pkg::CELL_PRISM:
            begin
                if (u == 4'd6)
                begin
                    nk = dcc_pkg::K_PRISM;
                    v  = orig;
                end else if (u == 4'd1)
                begin
                    nk   = dcc_pkg::K_NODE;
                    v[0] = wid(t[0]);
                end else if (u == 4'd5)
                begin
                    nk = dcc_pkg::K_PYRA;
                    if (eq[1][4])
                    begin
                        v[0] = wid(t[0]);
                        v[1] = wid(t[2]);
                        v[2] = wid(t[5]);
                        v[3] = wid(t[3]);
                        v[4] = wid(t[4]);
                    end else if (eq[2][5])
                    begin
                        v[0] = wid(t[1]);
                        v[1] = wid(t[0]);
                        v[2] = wid(t[3]);
                        v[3] = wid(t[4]);
                        v[4] = wid(t[2]);
                    end else if (eq[0][3])
                    begin
                        v[0] = wid(t[1]);
                        v[1] = wid(t[4]);
                        v[2] = wid(t[5]);
                        v[3] = wid(t[2]);
                        v[4] = wid(t[0]);
                    end else
                    begin
                        nk = dcc_pkg::K_INVALID;
                    end
                end else if (u == 4'd4 && eq[0][1] && eq[1][2])
                begin
                    // lower face collapsed to a point
                    nk   = dcc_pkg::K_TET;
                    v[0] = wid(t[3]);
                    v[1] = wid(t[5]);
                    v[2] = wid(t[4]);
                    v[3] = wid(t[0]);
                end else if (u == 4'd4 && eq[3][4] && eq[4][5])
                begin
                    nk   = dcc_pkg::K_TET;
                    v[0] = wid(t[0]);
                    v[1] = wid(t[1]);
                    v[2] = wid(t[2]);
                    v[3] = wid(t[3]);
                end else
                begin
                    nk = dcc_pkg::K_PRISM;
                    st = dcc_pkg::STATUS_UNSUP;
                    v  = orig;
                end
            end
            dcc_pkg::CELL_HEX:
            begin
                v = orig;
                if (u == 4'd8)
                begin
                    nk = dcc_pkg::K_HEX;
                end else if (u == 4'd1)
                begin
                    // all-equal hex keeps its ids
                    nk = dcc_pkg::K_NODE;
                end else if (u == 4'd6 && eq[0][1] && eq[2][3])
                begin
                    nk   = dcc_pkg::K_PRISM;
                    v[0] = wid(t[0]);
                    v[1] = wid(t[4]);
                    v[2] = wid(t[5]);
                    v[3] = wid(t[2]);
                    v[4] = wid(t[7]);
                    v[5] = wid(t[6]);
                    v[6] = dcc_pkg::UNUSED_ID;
                    v[7] = dcc_pkg::UNUSED_ID;
                end else if (u == 4'd6 && eq[1][5] && eq[2][6])
                begin
                    nk   = dcc_pkg::K_PRISM;
                    v[0] = wid(t[0]);
                    v[1] = wid(t[4]);
                    v[2] = wid(t[1]);
                    v[3] = wid(t[3]);
                    v[4] = wid(t[7]);
                    v[5] = wid(t[2]);
                    v[6] = dcc_pkg::UNUSED_ID;
                    v[7] = dcc_pkg::UNUSED_ID;
                end else if (u == 4'd6 && eq[0][4] && eq[3][7])
                begin
                    nk   = dcc_pkg::K_PRISM;
                    v[0] = wid(t[0]);
                    v[1] = wid(t[5]);
                    v[2] = wid(t[1]);
                    v[3] = wid(t[3]);
                    v[4] = wid(t[6]);
                    v[5] = wid(t[2]);
                    v[6] = dcc_pkg::UNUSED_ID;
                    v[7] = dcc_pkg::UNUSED_ID;
                end else
                begin
                    nk = dcc_pkg::K_HEX;
                    st = dcc_pkg::STATUS_UNSUP;
                end
            end
            default:
            begin
                nk = dcc_pkg::K_INVALID;
                st = dcc_pkg::STATUS_UNSUP;
            end
        endcase
    end

    assign res_out.new_kind = nk;
    assign res_out.status   = st;
    assign res_out.out0     = v[0];
    assign res_out.out1     = v[1];
    assign res_out.out2     = v[2];
    assign res_out.out3     = v[3];
    assign res_out.out4     = v[4];
    assign res_out.out5     = v[5];
    assign res_out.out6     = v[6];
    assign res_out.out7     = v[7];

endmodule

[hw/rtl/degenerate_cell_collapse.sv]
// Top level of the degenerate mesh cell collapse block.
//
// Usage:
//   mesh_cell (sink)   : one mesh cell per request - kind code and eight node ids.
//   result (source)    : one result per cell - new kind, status and eight
//                        rewritten ids, freed slots reading -1.
//   A request moves on a rising edge of clk with valid and ready both high.
//
// Timing:
//   Two register stages: the input register holds the accepted cell, the
//   compare-and-permute logic between them is combinational, and the
//   result register drives the result channel. An accepted cell moves from
//   the input register into the result register, which raises result.valid,
//   once the result register is free. Throughput is one cell per cycle while
//   result.ready stays high; the limit is the 28-way id compare and distinct
//   count feeding the rewrite mux.
//
// Reset (rst_n low, asynchronous) empties both stages; nothing is held.
// Stall: when the receiver holds ready low the result register keeps its
//   request and the input register still takes one more cell; mesh_cell.ready
//   drops only when both stages are full.
`include "degenerate_cell_collapse_macros.svh"

module degenerate_cell_collapse (
    input  logic               clk,
    input  logic               rst_n,
    dcc_cell_if.sink           mesh_cell,
    dcc_result_if.source       result
);

    logic               in_valid_reg;
    logic               in_valid_next;
    dcc_pkg::cell_t     in_data_reg;
    dcc_pkg::cell_t     in_data_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    dcc_pkg::result_t   out_data_reg;
    dcc_pkg::result_t   res_comb;
    logic               out_free;
    logic               in_free;

    // Output stage can load when empty or being drained this cycle
    assign out_free = !out_valid_reg || result.ready;
    assign in_free  = !in_valid_reg || out_free;

    assign mesh_cell.ready = in_free;

    assign in_data_next.cell_kind = mesh_cell.cell_kind;
    assign in_data_next.id0       = mesh_cell.id0;
    assign in_data_next.id1       = mesh_cell.id1;
    assign in_data_next.id2       = mesh_cell.id2;
    assign in_data_next.id3       = mesh_cell.id3;
    assign in_data_next.id4       = mesh_cell.id4;
    assign in_data_next.id5       = mesh_cell.id5;
    assign in_data_next.id6       = mesh_cell.id6;
    assign in_data_next.id7       = mesh_cell.id7;

    assign in_valid_next  = in_free ? mesh_cell.valid : in_valid_reg;
    assign out_valid_next = out_free ? in_valid_reg : out_valid_reg;

    dcc_collapse u_collapse (
        .cell_in (in_data_reg),
        .res_out (res_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_free && mesh_cell.valid)
        begin
            in_data_reg <= in_data_next;
        end
        if (out_free && in_valid_reg)
        begin
            out_data_reg <= res_comb;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.new_kind = out_data_reg.new_kind;
    assign result.status   = out_data_reg.status;
    assign result.out0     = out_data_reg.out0;
    assign result.out1     = out_data_reg.out1;
    assign result.out2     = out_data_reg.out2;
    assign result.out3     = out_data_reg.out3;
    assign result.out4     = out_data_reg.out4;
    assign result.out5     = out_data_reg.out5;
    assign result.out6     = out_data_reg.out6;
    assign result.out7     = out_data_reg.out7;

    // A cell in the input stage moves on or waits; it is never dropped
    `DCC_ASSERT_NXT(a_in_to_out, in_valid_reg && out_free, out_valid_reg)
    `DCC_ASSERT_NXT(a_in_held, in_valid_reg && !out_free, in_valid_reg)
    // Unsupported status only carries a volume kind code or invalid
    `DCC_ASSERT_IMP(a_unsup_kind, result.valid && result.status,
        result.new_kind == dcc_pkg::K_TET || result.new_kind == dcc_pkg::K_PRISM ||
        result.new_kind == dcc_pkg::K_HEX || result.new_kind == dcc_pkg::K_INVALID)
    // An invalid cell has every slot freed; out0 and out7 are checked
    `DCC_ASSERT_IMP(a_invalid_free, result.valid && result.new_kind == dcc_pkg::K_INVALID,
        result.out0 == dcc_pkg::UNUSED_ID && result.out7 == dcc_pkg::UNUSED_ID)

endmodule
